>>> rtl/pwsa_pkg.sv
// Shared types, constants and helpers for the perspective warp source address core.
package pwsa_pkg;

  localparam int SRC_WIDTH   = 1920;
  localparam int SRC_HEIGHT  = 1080;
  localparam int MAX_OUT_DIM = 4096;

  localparam int XW  = 12;
  localparam int AW  = 11;
  localparam int CW  = 32;
  localparam int HW  = XW + 2;
  localparam int PW  = CW + HW;
  localparam int SW  = PW + 2;
  localparam int DW  = SW + 14;
  localparam int PAW = 5;
  localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int QW  = $clog2(SRC_MAX + 1);
  localparam int FRAC_SHIFT = 29;

  localparam logic [1:0] FILL_NONE     = 2'd0;
  localparam logic [1:0] FILL_ZERO_DEN = 2'd1;
  localparam logic [1:0] FILL_OUTSIDE  = 2'd2;

  localparam logic [2:0] REG_COEF_U_FROM_X = 3'd0;
  localparam logic [2:0] REG_COEF_U_FROM_Y = 3'd1;
  localparam logic [2:0] REG_OFFSET_U      = 3'd2;
  localparam logic [2:0] REG_COEF_V_FROM_X = 3'd3;
  localparam logic [2:0] REG_COEF_V_FROM_Y = 3'd4;
  localparam logic [2:0] REG_OFFSET_V      = 3'd5;
  localparam logic [2:0] REG_PERSP_FROM_X  = 3'd6;
  localparam logic [2:0] REG_PERSP_FROM_Y  = 3'd7;

  typedef struct packed {
    logic [XW-1:0] out_x;
    logic [XW-1:0] out_y;
  } in_beat_t;

  typedef struct packed {
    logic [AW-1:0] src_x;
    logic [AW-1:0] src_y;
    logic          use_fill;
    logic [1:0]    fill_cause;
  } out_beat_t;

  typedef struct packed {
    logic signed [CW-1:0] coef_u_from_x;
    logic signed [CW-1:0] coef_u_from_y;
    logic signed [CW-1:0] offset_u;
    logic signed [CW-1:0] coef_v_from_x;
    logic signed [CW-1:0] coef_v_from_y;
    logic signed [CW-1:0] offset_v;
    logic signed [CW-1:0] persp_from_x;
    logic signed [CW-1:0] persp_from_y;
  } cfg_t;

  function automatic logic signed [HW-1:0] half_units(input logic [XW-1:0] c);
    logic [XW-1:0] m;
    m = c;
    if (m > XW'(MAX_OUT_DIM - 1)) begin
      m = XW'(MAX_OUT_DIM - 1);
    end
    return {1'b0, m, 1'b1};
  endfunction

endpackage

>>> rtl/pwsa_cfg_regs.sv
// APB-style register file holding the eight transform coefficients.
module pwsa_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [pwsa_pkg::PAW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output pwsa_pkg::cfg_t         cfg_o
);
  import pwsa_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{coef_u_from_x: CW'(1 << 20), coef_v_from_y: CW'(1 << 20), default: '0};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_COEF_U_FROM_X: cfg_q.coef_u_from_x <= pwdata;
        REG_COEF_U_FROM_Y: cfg_q.coef_u_from_y <= pwdata;
        REG_OFFSET_U:      cfg_q.offset_u      <= pwdata;
        REG_COEF_V_FROM_X: cfg_q.coef_v_from_x <= pwdata;
        REG_COEF_V_FROM_Y: cfg_q.coef_v_from_y <= pwdata;
        REG_OFFSET_V:      cfg_q.offset_v      <= pwdata;
        REG_PERSP_FROM_X:  cfg_q.persp_from_x  <= pwdata;
        REG_PERSP_FROM_Y:  cfg_q.persp_from_y  <= pwdata;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEF_U_FROM_X: prdata = cfg_q.coef_u_from_x;
      REG_COEF_U_FROM_Y: prdata = cfg_q.coef_u_from_y;
      REG_OFFSET_U:      prdata = cfg_q.offset_u;
      REG_COEF_V_FROM_X: prdata = cfg_q.coef_v_from_x;
      REG_COEF_V_FROM_Y: prdata = cfg_q.coef_v_from_y;
      REG_OFFSET_V:      prdata = cfg_q.offset_v;
      REG_PERSP_FROM_X:  prdata = cfg_q.persp_from_x;
      REG_PERSP_FROM_Y:  prdata = cfg_q.persp_from_y;
      default:           prdata = '0;
    endcase
  end

endmodule

>>> rtl/pwsa_map.sv
// Front pipeline: products, sums, sign normalization and frame checks.
module pwsa_map (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  pwsa_pkg::in_beat_t      beat_i,
  input  pwsa_pkg::cfg_t          cfg_i,
  output logic                    valid_o,
  output logic                    fill_o,
  output logic [1:0]              cause_o,
  output logic [pwsa_pkg::DW-1:0] num_u_o,
  output logic [pwsa_pkg::DW-1:0] num_v_o,
  output logic [pwsa_pkg::DW-1:0] dvs_o
);
  import pwsa_pkg::*;

  logic signed [HW-1:0] ix, iy;
  logic signed [PW-1:0] p_q [6];
  logic signed [CW-1:0] off_u_q, off_v_q;
  logic signed [SW-1:0] nu_q, nv_q, den_q;
  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] dabs, nus, nvs, lim_u, lim_v;
  logic                 zero, outside;
  logic [DW-1:0]        num_u_q, num_v_q, dvs_q;
  logic                 fill_q;
  logic [1:0]           cause_q;

  assign ix = half_units(beat_i.out_x);
  assign iy = half_units(beat_i.out_y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= PW'(cfg_i.coef_u_from_x * ix);
      p_q[1]  <= PW'(cfg_i.coef_u_from_y * iy);
      p_q[2]  <= PW'(cfg_i.coef_v_from_x * ix);
      p_q[3]  <= PW'(cfg_i.coef_v_from_y * iy);
      p_q[4]  <= PW'(cfg_i.persp_from_x * ix);
      p_q[5]  <= PW'(cfg_i.persp_from_y * iy);
      off_u_q <= cfg_i.offset_u;
      off_v_q <= cfg_i.offset_v;
      nu_q    <= SW'(p_q[0]) + SW'(p_q[1]) + (SW'(off_u_q) <<< 5);
      nv_q    <= SW'(p_q[2]) + SW'(p_q[3]) + (SW'(off_v_q) <<< 5);
      den_q   <= SW'(p_q[4]) + SW'(p_q[5]) + SW'(1 << FRAC_SHIFT);
    end
  end

  always_comb begin
    zero  = (den_q == '0);
    dabs  = den_q[SW-1] ? -DW'(den_q) : DW'(den_q);
    nus   = (den_q[SW-1] ? -DW'(nu_q) : DW'(nu_q)) <<< 8;
    nvs   = (den_q[SW-1] ? -DW'(nv_q) : DW'(nv_q)) <<< 8;
    lim_u = DW'(SRC_WIDTH) * dabs;
    lim_v = DW'(SRC_HEIGHT) * dabs;
    outside = nus[DW-1] || (nus > lim_u) || nvs[DW-1] || (nvs > lim_v);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero) begin
        fill_q  <= 1'b1;
        cause_q <= FILL_ZERO_DEN;
      end else if (outside) begin
        fill_q  <= 1'b1;
        cause_q <= FILL_OUTSIDE;
      end else begin
        fill_q  <= 1'b0;
        cause_q <= FILL_NONE;
      end
      num_u_q <= DW'((nus <<< 1) + dabs);
      num_v_q <= DW'((nvs <<< 1) + dabs);
      dvs_q   <= zero ? DW'(1) : DW'(dabs <<< 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign fill_o  = fill_q;
  assign cause_o = cause_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign dvs_o   = dvs_q;

endmodule

>>> rtl/pwsa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module pwsa_div (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [pwsa_pkg::DW-1:0] num_i,
  input  logic [pwsa_pkg::DW-1:0] dvs_i,
  output logic [pwsa_pkg::QW-1:0] quo_o
);
  import pwsa_pkg::*;

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] dvs_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in, d_in, sh;
    logic [QW-1:0] q_in;
    logic          take;

    if (k == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = dvs_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = dvs_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign sh   = d_in << (QW - 1 - k);
    assign take = (r_in >= sh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {q_in[QW-2:0], take};
      end
    end

    if (k < QW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (r_in - sh) : r_in;
          dvs_q[k] <= d_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

>>> rtl/perspective_warp_source_address_core.sv
// Top level of the perspective warp source address core.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   in_beat_i  (out_x, out_y)
//   out      output     out_valid_o / out_ready_i out_beat_o (src_x, src_y, use_fill, fill_cause)
//   cfg      input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One beat enters per cycle unless a held output stalls the pipeline. Each beat passes three front
// stages for the products, sums and frame checks, then one divider stage per quotient bit (11).
// The whole pipeline advances together; a held output stalls every stage, and no
// beat is lost or repeated. Reset clears the valid bits and loads the identity
// transform.
module perspective_warp_source_address_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pwsa_pkg::in_beat_t        in_beat_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pwsa_pkg::out_beat_t       out_beat_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pwsa_pkg::PAW-1:0]  paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pwsa_pkg::*;

  cfg_t          cfg;
  logic          adv;
  logic          f_valid, f_fill;
  logic [1:0]    f_cause;
  logic [DW-1:0] f_num_u, f_num_v, f_dvs;
  logic [QW-1:0] quo_u, quo_v;
  logic          vld_q  [QW];
  logic          fill_q [QW];
  logic [1:0]    cause_q [QW];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  pwsa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwsa_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .cfg_i   (cfg),
    .valid_o (f_valid),
    .fill_o  (f_fill),
    .cause_o (f_cause),
    .num_u_o (f_num_u),
    .num_v_o (f_num_v),
    .dvs_o   (f_dvs)
  );

  pwsa_div u_div_u (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (f_num_u),
    .dvs_i (f_dvs),
    .quo_o (quo_u)
  );

  pwsa_div u_div_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (f_num_v),
    .dvs_i (f_dvs),
    .quo_o (quo_v)
  );

  for (genvar k = 0; k < QW; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= (k == 0) ? f_valid : vld_q[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        fill_q[k]  <= (k == 0) ? f_fill  : fill_q[(k == 0) ? 0 : k - 1];
        cause_q[k] <= (k == 0) ? f_cause : cause_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid_o = vld_q[QW-1];

  always_comb begin
    out_beat_o.use_fill   = fill_q[QW-1];
    out_beat_o.fill_cause = cause_q[QW-1];
    if (fill_q[QW-1]) begin
      out_beat_o.src_x = '0;
      out_beat_o.src_y = '0;
    end else begin
      out_beat_o.src_x = (quo_u > QW'(SRC_WIDTH - 1))  ? AW'(SRC_WIDTH - 1)  : AW'(quo_u);
      out_beat_o.src_y = (quo_v > QW'(SRC_HEIGHT - 1)) ? AW'(SRC_HEIGHT - 1) : AW'(quo_v);
    end
  end

endmodule

>>> test/tb.sv
// Self-checking testbench for the perspective warp source address core.
module tb;
  import pwsa_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    bit         wr;
    logic [2:0] idx;
    logic [31:0] val;
    in_beat_t   px;
    bit         known;
    out_beat_t  res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_beat_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_beat_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cfg_t        warp_cfg;
  out_beat_t   pending_addr[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_cycles = 0;

  perspective_warp_source_address_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic report_mismatch(string what, int want, int got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_addr.size() == 0) begin
        report_mismatch("unexpected beat", 0, 1);
      end else begin
        want = pending_addr.pop_front();
        if (out_beat_o.src_x != want.src_x)
          report_mismatch("src_x", want.src_x, out_beat_o.src_x);
        if (out_beat_o.src_y != want.src_y)
          report_mismatch("src_y", want.src_y, out_beat_o.src_y);
        if (out_beat_o.use_fill != want.use_fill)
          report_mismatch("use_fill", want.use_fill, out_beat_o.use_fill);
        if (out_beat_o.fill_cause != want.fill_cause)
          report_mismatch("fill_cause", want.fill_cause, out_beat_o.fill_cause);
      end
    end
  end

  function automatic out_beat_t warp_pixel(cfg_t c, in_beat_t b);
    longint ix, iy, den, nu, nv, q;
    out_beat_t r;
    ix = 2 * longint'((b.out_x > MAX_OUT_DIM - 1) ? MAX_OUT_DIM - 1 : b.out_x) + 1;
    iy = 2 * longint'((b.out_y > MAX_OUT_DIM - 1) ? MAX_OUT_DIM - 1 : b.out_y) + 1;
    den = longint'(c.persp_from_x) * ix + longint'(c.persp_from_y) * iy
          + (longint'(1) << FRAC_SHIFT);
    nu = longint'(c.coef_u_from_x) * ix + longint'(c.coef_u_from_y) * iy
         + longint'(c.offset_u) * 32;
    nv = longint'(c.coef_v_from_x) * ix + longint'(c.coef_v_from_y) * iy
         + longint'(c.offset_v) * 32;
    r = '{src_x: '0, src_y: '0, use_fill: 1'b1, fill_cause: FILL_ZERO_DEN};
    if (den == 0) return r;
    nu = nu * 256;
    nv = nv * 256;
    if (den < 0) begin
      den = -den;
      nu = -nu;
      nv = -nv;
    end
    if (nu < 0 || nu > SRC_WIDTH * den || nv < 0 || nv > SRC_HEIGHT * den) begin
      r.fill_cause = FILL_OUTSIDE;
      return r;
    end
    q = (2 * nu + den) / (2 * den);
    r.src_x = AW'((q > SRC_WIDTH - 1) ? SRC_WIDTH - 1 : q);
    q = (2 * nv + den) / (2 * den);
    r.src_y = AW'((q > SRC_HEIGHT - 1) ? SRC_HEIGHT - 1 : q);
    r.use_fill = 1'b0;
    r.fill_cause = FILL_NONE;
    return r;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_addr.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAW'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COEF_U_FROM_X: warp_cfg.coef_u_from_x = val;
      REG_COEF_U_FROM_Y: warp_cfg.coef_u_from_y = val;
      REG_OFFSET_U:      warp_cfg.offset_u = val;
      REG_COEF_V_FROM_X: warp_cfg.coef_v_from_x = val;
      REG_COEF_V_FROM_Y: warp_cfg.coef_v_from_y = val;
      REG_OFFSET_V:      warp_cfg.offset_v = val;
      REG_PERSP_FROM_X:  warp_cfg.persp_from_x = val;
      default:           warp_cfg.persp_from_y = val;
    endcase
  endtask

  task automatic send_pixel(in_beat_t px, bit known, out_beat_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pending_addr.push_back(known ? res : warp_pixel(warp_cfg, px));
  endtask

  function automatic logic [31:0] srand(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic load_warp(int kind);
    logic [31:0] v[8];
    case (kind)
      1: foreach (v[i]) v[i] = 32'h7FFF_FFFF;
      2: foreach (v[i]) v[i] = 32'h8000_0000;
      3: foreach (v[i]) v[i] = $urandom;
      default: begin
        v[0] = 32'(1 << 20) + srand(1 << 19);
        v[1] = srand(1 << 17);
        v[2] = srand(300 << 16);
        v[3] = srand(1 << 17);
        v[4] = 32'(1 << 20) + srand(1 << 19);
        v[5] = srand(300 << 16);
        v[6] = srand(1 << 14);
        v[7] = srand(1 << 14);
      end
    endcase
    foreach (v[i]) write_reg(3'(i), v[i]);
  endtask

  row_t directed[] = '{
    '{0, REG_COEF_U_FROM_X, 0, '{12'd0, 12'd0}, 1, '{11'd1, 11'd1, 1'b0, FILL_NONE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd1918, 12'd1078}, 1,
      '{11'd1919, 11'd1079, 1'b0, FILL_NONE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd1919, 12'd1079}, 1,
      '{11'd1919, 11'd1079, 1'b0, FILL_NONE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd1920, 12'd0}, 1, '{11'd0, 11'd0, 1'b1, FILL_OUTSIDE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd0, 12'd1080}, 1, '{11'd0, 11'd0, 1'b1, FILL_OUTSIDE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd4095, 12'd4095}, 1,
      '{11'd0, 11'd0, 1'b1, FILL_OUTSIDE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd5, 12'd7}, 1, '{11'd6, 11'd8, 1'b0, FILL_NONE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'hAAA, 12'h555}, 0, '0},
    '{0, REG_COEF_U_FROM_X, 0, '{12'h555, 12'hAAA}, 0, '0},
    '{1, REG_OFFSET_U, 32'hFFFF_0000, '{12'd0, 12'd0}, 1,
      '{11'd0, 11'd0, 1'b1, FILL_OUTSIDE}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd1, 12'd1}, 0, '0},
    '{1, REG_PERSP_FROM_X, 32'hE000_0000, '{12'd0, 12'd0}, 1,
      '{11'd0, 11'd0, 1'b1, FILL_ZERO_DEN}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd0, 12'd900}, 1, '{11'd0, 11'd0, 1'b1, FILL_ZERO_DEN}},
    '{0, REG_COEF_U_FROM_X, 0, '{12'd1, 12'd0}, 0, '0},
    '{1, REG_PERSP_FROM_X, 32'hC000_0000, '{12'd0, 12'd0}, 0, '0},
    '{1, REG_PERSP_FROM_Y, 32'h0000_0100, '{12'd3, 12'd3}, 0, '0}
  };

  initial begin
    in_beat_t px;
    warp_cfg = '{coef_u_from_x: 32'sd1048576, coef_v_from_y: 32'sd1048576, default: '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      if (directed[i].wr) write_reg(directed[i].idx, directed[i].val);
      send_pixel(directed[i].px, directed[i].known, directed[i].res);
    end
    for (int ph = 0; ph < 8; ph++) begin
      in_valid_i <= 1'b0;
      load_warp(ph == 1 ? 1 : ph == 3 ? 2 : ph == 6 ? 3 : 0);
      send_idle  = (ph % 4 == 1) ? 84 : (ph % 4 == 3) ? 29 : 0;
      recv_stall = (ph % 4 == 2) ? 84 : (ph % 4 == 3) ? 29 : 0;
      for (int n = 0; n < 50; n++) begin
        if (ph == 4 && n == 10) hold_cycles = 80;
        if (ph == 5 && n == 25) begin
          in_valid_i <= 1'b0;
          drain();
        end
        if ($urandom_range(99) < 80) begin
          px.out_x = 12'($urandom_range(2047));
          px.out_y = 12'($urandom_range(1279));
        end else begin
          px.out_x = 12'($urandom);
          px.out_y = 12'($urandom);
        end
        send_pixel(px, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pwsa_pkg.sv
rtl/pwsa_cfg_regs.sv
rtl/pwsa_map.sv
rtl/pwsa_div.sv
rtl/perspective_warp_source_address_core.sv
test/tb.sv
